// ===== sv/vgsb_pkg.sv =====
// ----------------------------------------------------------------------------
// Voxel grid sphere brush package
// Grid geometry, field widths, operation codes and controller states.
// ----------------------------------------------------------------------------
package vgsb_pkg;

  localparam int GRID_X      = 256;
  localparam int GRID_Y      = 256;
  localparam int GRID_Z      = 128;
  localparam int MAX_RADIUS  = 15;

  localparam int WORD_W      = 32;
  localparam int BIT_W       = 5;
  localparam int WORDS_Z     = (GRID_Z + WORD_W - 1) / WORD_W;
  localparam int TOTAL_WORDS = GRID_X * GRID_Y * WORDS_Z;
  localparam int ADDR_W      = $clog2(TOTAL_WORDS);

  localparam int X_W         = $clog2(GRID_X);
  localparam int Y_W         = $clog2(GRID_Y);
  localparam int Z_W         = $clog2(GRID_Z);

  localparam int POS_X_W     = 8;
  localparam int POS_Y_W     = 8;
  localparam int POS_Z_W     = 7;
  localparam int OP_W        = 2;
  localparam int R_W         = 4;
  localparam int D_W         = R_W + 2;
  localparam int C_W         = 12;
  localparam int SQ_W        = 2 * D_W + 2;

  typedef enum logic [OP_W-1:0] {
    OP_PAINT = 2'd0,
    OP_ERASE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_STAMP,
    S_READ,
    S_RDWAIT,
    S_CLEAR,
    S_RESP
  } state_t;

endpackage

// ===== sv/voxel_grid_sphere_brush.sv =====
// ----------------------------------------------------------------------------
// Voxel grid sphere brush
// One-bit occupancy grid packed as 32-bit words along z. Paint and erase
// stamp a solid sphere, clear zeroes the grid, read returns one word.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Word
//  in_      input      in_valid/in_ready     in_operation, in_pos_x/y/z
//  out_     output     out_valid/out_ready   out_read_data
//  cfg_     input      cfg_valid/cfg_ready   cfg_brush_radius
//
//  Paint and erase visit (2r+1)^3 offsets, one read-modify-write per cycle.
//  Clear sweeps all 262144 words of the memory, one word a cycle. The same
//  sweep runs after reset, during which no word is accepted. The result
//  register lets the next word enter while a result still waits on out_ready.
//
module voxel_grid_sphere_brush (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vgsb_pkg::OP_W-1:0]     in_operation,
  input  logic [vgsb_pkg::POS_X_W-1:0]  in_pos_x,
  input  logic [vgsb_pkg::POS_Y_W-1:0]  in_pos_y,
  input  logic [vgsb_pkg::POS_Z_W-1:0]  in_pos_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vgsb_pkg::WORD_W-1:0]   out_read_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vgsb_pkg::R_W-1:0]      cfg_brush_radius
);

  import vgsb_pkg::*;

  function automatic logic [ADDR_W-1:0] word_addr(input logic [X_W-1:0] xa,
                                                  input logic [Y_W-1:0] ya,
                                                  input logic [Z_W-1:0] za);
    logic [ADDR_W-1:0] col;
    col = ADDR_W'(xa) * ADDR_W'(GRID_Y) + ADDR_W'(ya);
    return col * ADDR_W'(WORDS_Z) + ADDR_W'(za >> BIT_W);
  endfunction

  state_t state_r, state_nxt;

  logic [R_W-1:0]     radius_r, radius_nxt;
  logic [R_W-1:0]     r_r, r_nxt;
  op_t                op_r, op_nxt;
  logic [POS_X_W-1:0] px_r, px_nxt;
  logic [POS_Y_W-1:0] py_r, py_nxt;
  logic [POS_Z_W-1:0] pz_r, pz_nxt;
  logic [D_W-1:0]     dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  logic [ADDR_W-1:0]  clr_cnt_r, clr_cnt_nxt;

  logic               s1_v_r, s1_v_nxt;
  logic               s1_rd_r, s1_rd_nxt;
  logic               s1_zero_r, s1_zero_nxt;
  logic               s1_paint_r, s1_paint_nxt;
  logic [ADDR_W-1:0]  s1_addr_r, s1_addr_nxt;
  logic [BIT_W-1:0]   s1_bit_r, s1_bit_nxt;

  logic               fw_v_r, fw_v_nxt;
  logic [ADDR_W-1:0]  fw_addr_r, fw_addr_nxt;
  logic [WORD_W-1:0]  fw_data_r, fw_data_nxt;

  logic [WORD_W-1:0]  res_data_r, res_data_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]  out_data_r, out_data_nxt;

  logic               in_fire;
  logic               issue_stamp, issue_read, clearing, stamp_last, out_load;
  logic signed [C_W-1:0]  vx, vy, vz;
  logic signed [D_W-1:0]  sdx, sdy, sdz;
  logic signed [SQ_W-1:0] ex, ey, ez;
  logic [SQ_W-1:0]        dist2;
  logic [2*R_W-1:0]       r2;
  logic               v_inside, v_sphere, rd_inside;
  logic [ADDR_W-1:0]  stamp_addr, read_addr;
  logic [WORD_W-1:0]  ram_rdata, merged, bit_mask, s1_wdata;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;

  assign in_ready      = (state_r == S_IDLE);
  assign in_fire       = in_valid && in_ready;
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  // Current voxel of the brush scan.
  always_comb begin
    sdx   = $signed(dx_r);
    sdy   = $signed(dy_r);
    sdz   = $signed(dz_r);
    ex    = SQ_W'(sdx);
    ey    = SQ_W'(sdy);
    ez    = SQ_W'(sdz);
    vx    = $signed({{(C_W-POS_X_W){1'b0}}, px_r}) + C_W'(sdx);
    vy    = $signed({{(C_W-POS_Y_W){1'b0}}, py_r}) + C_W'(sdy);
    vz    = $signed({{(C_W-POS_Z_W){1'b0}}, pz_r}) + C_W'(sdz);
    dist2 = $unsigned(ex * ex) + $unsigned(ey * ey) + $unsigned(ez * ez);
    r2    = r_r * r_r;
    v_inside = !vx[C_W-1] && ($unsigned(vx) < C_W'(GRID_X))
            && !vy[C_W-1] && ($unsigned(vy) < C_W'(GRID_Y))
            && !vz[C_W-1] && ($unsigned(vz) < C_W'(GRID_Z));
    v_sphere = (dist2 <= SQ_W'(r2));
    stamp_addr = word_addr(vx[X_W-1:0], vy[Y_W-1:0], vz[Z_W-1:0]);
    rd_inside = (C_W'(px_r) < C_W'(GRID_X)) && (C_W'(py_r) < C_W'(GRID_Y))
             && (C_W'(pz_r) < C_W'(GRID_Z));
    read_addr = word_addr(X_W'(px_r), Y_W'(py_r), Z_W'(pz_r));
    stamp_last = (dx_r == D_W'(r_r)) && (dy_r == D_W'(r_r)) && (dz_r == D_W'(r_r));
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (clr_cnt_r == ADDR_W'(TOTAL_WORDS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          case (op_t'(in_operation))
            OP_PAINT: state_nxt = S_STAMP;
            OP_ERASE: state_nxt = S_STAMP;
            OP_CLEAR: state_nxt = S_CLEAR;
            OP_READ:  state_nxt = S_READ;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_STAMP: begin
        if (stamp_last) state_nxt = S_RESP;
      end
      S_READ:   state_nxt = S_RDWAIT;
      S_RDWAIT: state_nxt = S_RESP;
      S_CLEAR: begin
        if (clr_cnt_r == ADDR_W'(TOTAL_WORDS - 1)) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // Controller outputs.
  always_comb begin
    issue_stamp = 1'b0;
    issue_read  = 1'b0;
    clearing    = 1'b0;
    out_load    = 1'b0;
    case (state_r)
      S_INIT:   clearing    = 1'b1;
      S_CLEAR:  clearing    = 1'b1;
      S_STAMP:  issue_stamp = 1'b1;
      S_READ:   issue_read  = 1'b1;
      S_RESP:   out_load    = !out_valid_r || out_ready;
      default: begin
      end
    endcase
  end

  // Scan counters, item registers and pipeline stage one.
  always_comb begin
    radius_nxt = cfg_valid ? cfg_brush_radius : radius_r;
    op_nxt  = op_r;
    px_nxt  = px_r;
    py_nxt  = py_r;
    pz_nxt  = pz_r;
    r_nxt   = r_r;
    dx_nxt  = dx_r;
    dy_nxt  = dy_r;
    dz_nxt  = dz_r;
    clr_cnt_nxt  = clearing ? clr_cnt_r + 1'b1 : '0;
    res_data_nxt = res_data_r;
    if (in_fire) begin
      op_nxt = op_t'(in_operation);
      px_nxt = in_pos_x;
      py_nxt = in_pos_y;
      pz_nxt = in_pos_z;
      r_nxt  = (32'(radius_r) > MAX_RADIUS) ? R_W'(MAX_RADIUS) : radius_r;
      dx_nxt = -D_W'(r_nxt);
      dy_nxt = -D_W'(r_nxt);
      dz_nxt = -D_W'(r_nxt);
      res_data_nxt = '0;
    end else if (issue_stamp) begin
      if (dz_r != D_W'(r_r)) begin
        dz_nxt = dz_r + 1'b1;
      end else begin
        dz_nxt = -D_W'(r_r);
        if (dy_r != D_W'(r_r)) begin
          dy_nxt = dy_r + 1'b1;
        end else begin
          dy_nxt = -D_W'(r_r);
          dx_nxt = dx_r + 1'b1;
        end
      end
    end
    if (s1_rd_r) begin
      res_data_nxt = s1_zero_r ? '0 : merged;
    end

    s1_v_nxt     = issue_stamp && v_inside && v_sphere;
    s1_rd_nxt    = issue_read;
    s1_zero_nxt  = !rd_inside;
    s1_paint_nxt = (op_r == OP_PAINT);
    s1_addr_nxt  = issue_read ? read_addr : stamp_addr;
    s1_bit_nxt   = issue_read ? BIT_W'(pz_r) : vz[BIT_W-1:0];
  end

  // Read-modify-write with forwarding of the write issued in the previous cycle.
  always_comb begin
    merged   = (fw_v_r && (fw_addr_r == s1_addr_r)) ? fw_data_r : ram_rdata;
    bit_mask = WORD_W'(1) << s1_bit_r;
    s1_wdata = s1_paint_r ? (merged | bit_mask) : (merged & ~bit_mask);
    ram_we    = s1_v_r || clearing;
    ram_waddr = clearing ? clr_cnt_r : s1_addr_r;
    ram_wdata = clearing ? '0 : s1_wdata;
    fw_v_nxt    = s1_v_r;
    fw_addr_nxt = s1_addr_r;
    fw_data_nxt = s1_wdata;
    out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    out_data_nxt  = out_load ? res_data_r : out_data_r;
  end

  vgsb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TOTAL_WORDS)
  ) u_words (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue_stamp || issue_read),
    .raddr (s1_addr_nxt),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      radius_r    <= R_W'(1);
      clr_cnt_r   <= '0;
      s1_v_r      <= 1'b0;
      s1_rd_r     <= 1'b0;
      fw_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      radius_r    <= radius_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      s1_v_r      <= s1_v_nxt;
      s1_rd_r     <= s1_rd_nxt;
      fw_v_r      <= fw_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    pz_r       <= pz_nxt;
    r_r        <= r_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    dz_r       <= dz_nxt;
    s1_zero_r  <= s1_zero_nxt;
    s1_paint_r <= s1_paint_nxt;
    s1_addr_r  <= s1_addr_nxt;
    s1_bit_r   <= s1_bit_nxt;
    fw_addr_r  <= fw_addr_nxt;
    fw_data_r  <= fw_data_nxt;
    res_data_r <= res_data_nxt;
    out_data_r <= out_data_nxt;
  end

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !s1_v_r)
    else $error("stamp write pending while idle");

  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(clearing && s1_v_r))
    else $error("clear sweep and stamp write in the same cycle");

  a_read_stage: assert property (@(posedge clk) disable iff (!rst_n)
    s1_rd_r |-> (state_r == S_RDWAIT))
    else $error("read data arrived outside the read wait state");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("second word accepted before the first finished");

  a_resp_loads: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result not presented after load");

endmodule

// ===== sv/vgsb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vgsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
